### hdl/eastw_pkg.sv
// ----------------------------------------------------------------------------
// eastw_pkg
// Shared types and constants for the US Eastern trading-window check: pipeline
// beat structures, reciprocal constants for the fixed divisions, and the
// calendar tables.
// ----------------------------------------------------------------------------
package eastw_pkg;

  // Configuration register indexes and reset values.
  localparam logic [1:0]  REG_OPEN_MINUTE  = 2'd0;
  localparam logic [1:0]  REG_CLOSE_MINUTE = 2'd1;
  localparam logic [10:0] OPEN_RESET       = 11'd570;
  localparam logic [10:0] CLOSE_RESET      = 11'd960;

  // Days from seconds: (epoch >> 7) / 675, exact for 25-bit operands.
  localparam logic [25:0] DAY_RECIP    = 26'd50903317;
  localparam int unsigned DAY_SHIFT    = 35;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;

  // Day of era relative to 0000-03-01, for the two eras the input can reach.
  localparam logic [15:0] ERA5_START_DAY = 16'd11017;
  localparam logic [17:0] ERA4_BIAS      = 18'd135080;
  localparam logic [17:0] DAYS_PER_CENT  = 18'd36524;
  localparam logic [17:0] LAST_ERA_DAY   = 18'd146096;

  // x / 365 as (x * R365) >> 25, exact for x below about 1.8 million.
  localparam logic [16:0] R365       = 17'd91930;
  localparam logic [17:0] DAYS_YEAR  = 18'd365;

  // x / 7 as (x * R7) >> 19, exact for 16-bit x.
  localparam logic [16:0] R7            = 17'd74899;
  localparam logic [15:0] DAYS_PER_WEEK = 16'd7;

  // x / 15 as (x * R15) >> 19, exact for 15-bit x (minute = (sec >> 2) / 15).
  localparam logic [15:0] R15 = 16'd34953;

  // UTC offsets in seconds.
  localparam logic [16:0] DST_OFFSET_S = 17'd14400;
  localparam logic [16:0] STD_OFFSET_S = 17'd18000;

  // Month codes counted from March, and weekday codes.
  localparam logic [3:0] MP_MARCH    = 4'd0;
  localparam logic [3:0] MP_APRIL    = 4'd1;
  localparam logic [3:0] MP_OCTOBER  = 4'd7;
  localparam logic [3:0] MP_NOVEMBER = 4'd8;
  localparam logic [2:0] WD_SUNDAY   = 3'd0;
  localparam logic [2:0] WD_MONDAY   = 3'd1;
  localparam logic [2:0] WD_FRIDAY   = 3'd5;
  localparam logic [2:0] WD_SATURDAY = 3'd6;

  // First day of year of each month, the year starting on March 1.
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };

  // Beat leaving the UTC split: day count and second of day.
  typedef struct packed {
    logic        valid;
    logic [15:0] days;
    logic [16:0] sod;
  } utc_beat_t;

  // Beat leaving the civil-date stages: DST decision and UTC weekday.
  typedef struct packed {
    logic        valid;
    logic        dst;
    logic [2:0]  wday;
    logic [16:0] sod;
  } civ_beat_t;

  // Trading window bounds.
  typedef struct packed {
    logic [10:0] open_minute;
    logic [10:0] close_minute;
  } win_cfg_t;

  // Month code from day of year (March based).
  function automatic logic [3:0] month_index(input logic [8:0] doy);
    logic [3:0] mp;
    mp = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (doy >= MONTH_START[k]) begin
        mp = 4'(k);
      end
    end
    return mp;
  endfunction

  // Remainder by seven of a small value below 42.
  function automatic logic [2:0] mod7_small(input logic [5:0] x);
    logic [5:0] r;
    if (x >= 6'd35) begin
      r = x - 6'd35;
    end else if (x >= 6'd28) begin
      r = x - 6'd28;
    end else if (x >= 6'd21) begin
      r = x - 6'd21;
    end else if (x >= 6'd14) begin
      r = x - 6'd14;
    end else if (x >= 6'd7) begin
      r = x - 6'd7;
    end else begin
      r = x;
    end
    return r[2:0];
  endfunction

endpackage

### hdl/eastw_utc_split.sv
// ----------------------------------------------------------------------------
// eastw_utc_split
// Splits the epoch into whole UTC days and the second of the day over two
// register stages: a reciprocal multiply, then a multiply-back and subtract.
// ----------------------------------------------------------------------------
module eastw_utc_split (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [31:0]          epoch_i,
  output eastw_pkg::utc_beat_t beat_o
);
  import eastw_pkg::*;

  logic        v1_q, v2_q;
  logic [31:0] ep1_q;
  logic [50:0] prod_d, prod_q;
  logic [15:0] days, days2_q;
  logic [16:0] sod, sod2_q;
  utc_beat_t   beat_d;

  // Stage one: scaled reciprocal product for the day count.
  assign prod_d = 51'(epoch_i[31:7]) * 51'(DAY_RECIP);

  // Stage two: day count and remainder seconds.
  assign days = prod_q[DAY_SHIFT+15:DAY_SHIFT];
  assign sod  = 17'(ep1_q - 32'(days) * 32'(SECS_PER_DAY));

  always_comb begin
    beat_d.valid = v1_q;
    beat_d.days  = days;
    beat_d.sod   = sod;
  end

  // Valid bits are reset; the payload flows without reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= beat_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ep1_q   <= epoch_i;
    prod_q  <= prod_d;
    days2_q <= beat_d.days;
    sod2_q  <= beat_d.sod;
  end

  always_comb begin
    beat_o.valid = v2_q;
    beat_o.days  = days2_q;
    beat_o.sod   = sod2_q;
  end

endmodule

### hdl/eastw_civil.sv
// ----------------------------------------------------------------------------
// eastw_civil
// Civil date and US daylight saving decision from the UTC day count. Five
// register stages: day of era, year of era, day of year, month and day, and
// finally the second-Sunday / first-Sunday rule.
// ----------------------------------------------------------------------------
module eastw_civil (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  eastw_pkg::utc_beat_t beat_i,
  output eastw_pkg::civ_beat_t beat_o
);
  import eastw_pkg::*;

  // Stage three registers.
  logic        v3_q;
  logic [15:0] days3_q;
  logic [16:0] sod3_q;
  logic [17:0] doe_d, doe3_q;
  logic [32:0] pc_d, pc_q;
  logic [32:0] p7_d, p7_q;

  // Stage four registers.
  logic        v4_q;
  logic [16:0] sod4_q;
  logic [17:0] doe4_q;
  logic [2:0]  wd_d, wd4_q;
  logic [17:0] n_d;
  logic [34:0] py_d, py_q;
  logic [15:0] q7;
  logic [7:0]  d1460;
  logic [2:0]  cents;

  // Stage five registers.
  logic        v5_q;
  logic [16:0] sod5_q;
  logic [2:0]  wd5_q;
  logic [8:0]  yoe;
  logic [1:0]  c100;
  logic [17:0] ybase;
  logic [8:0]  doy_d, doy_q;

  // Stage six registers.
  logic        v6_q;
  logic [16:0] sod6_q;
  logic [2:0]  wd6_q;
  logic [3:0]  mp_d, mp_q;
  logic [4:0]  mday_d, mday_q;

  // Stage seven.
  logic [2:0]  fs_rem;
  logic [3:0]  first_sun;
  logic        dst_d;
  civ_beat_t   beat_d;
  logic        v7_q, dst7_q;
  logic [2:0]  wd7_q;
  logic [16:0] sod7_q;

  // Day of era; the epoch range touches only two eras.
  always_comb begin
    if (beat_i.days >= ERA5_START_DAY) begin
      doe_d = 18'(beat_i.days) - 18'(ERA5_START_DAY);
    end else begin
      doe_d = 18'(beat_i.days) + ERA4_BIAS;
    end
  end
  assign pc_d = 33'(doe_d[17:2]) * 33'(R365);
  assign p7_d = 33'(beat_i.days) * 33'(R7);

  // UTC weekday (day zero was a Thursday) and the leap-corrected numerator
  // for the year of era.
  assign q7    = 16'(p7_q[32:19]);
  assign wd_d  = mod7_small(6'(days3_q - q7 * DAYS_PER_WEEK) + 6'd4);
  assign d1460 = pc_q[32:25];
  assign cents = 3'(doe3_q >= DAYS_PER_CENT) + 3'(doe3_q >= 18'(2) * DAYS_PER_CENT)
               + 3'(doe3_q >= 18'(3) * DAYS_PER_CENT) + 3'(doe3_q >= LAST_ERA_DAY);
  assign n_d   = doe3_q - 18'(d1460) + 18'(cents) - 18'(doe3_q >= LAST_ERA_DAY);
  assign py_d  = 35'(n_d) * 35'(R365);

  // Day of year within the March-based year.
  assign yoe   = py_q[33:25];
  assign c100  = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
  assign ybase = 18'(yoe) * DAYS_YEAR + 18'(yoe[8:2]) - 18'(c100);
  assign doy_d = 9'(doe4_q - ybase);

  // Month code and day of month.
  assign mp_d   = month_index(doy_q);
  assign mday_d = 5'(doy_q - MONTH_START[mp_d] + 9'd1);

  // Daylight saving: April to October always, March from the second Sunday,
  // November before the first Sunday.
  assign fs_rem    = mod7_small(6'(mday_q) + 6'd6 - 6'(wd6_q));
  assign first_sun = 4'(fs_rem) + 4'd1;
  always_comb begin
    dst_d = 1'b0;
    if (mp_q >= MP_APRIL && mp_q <= MP_OCTOBER) begin
      dst_d = 1'b1;
    end else if (mp_q == MP_MARCH) begin
      dst_d = (5'(first_sun) + 5'd7) <= mday_q;
    end else if (mp_q == MP_NOVEMBER) begin
      dst_d = mday_q < 5'(first_sun);
    end
    beat_d.valid = v6_q;
    beat_d.dst   = dst_d;
    beat_d.wday  = wd6_q;
    beat_d.sod   = sod6_q;
  end

  // Valid chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v3_q <= beat_i.valid;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= beat_d.valid;
    end
  end

  // Payload chain.
  always_ff @(posedge clk_i) begin
    days3_q <= beat_i.days;
    sod3_q  <= beat_i.sod;
    doe3_q  <= doe_d;
    pc_q    <= pc_d;
    p7_q    <= p7_d;
    sod4_q  <= sod3_q;
    doe4_q  <= doe3_q;
    wd4_q   <= wd_d;
    py_q    <= py_d;
    sod5_q  <= sod4_q;
    wd5_q   <= wd4_q;
    doy_q   <= doy_d;
    sod6_q  <= sod5_q;
    wd6_q   <= wd5_q;
    mp_q    <= mp_d;
    mday_q  <= mday_d;
    dst7_q  <= beat_d.dst;
    wd7_q   <= beat_d.wday;
    sod7_q  <= beat_d.sod;
  end

  always_comb begin
    beat_o.valid = v7_q;
    beat_o.dst   = dst7_q;
    beat_o.wday  = wd7_q;
    beat_o.sod   = sod7_q;
  end

endmodule

### hdl/eastw_local.sv
// ----------------------------------------------------------------------------
// eastw_local
// Shifts the UTC second of day to Eastern time, derives the Eastern weekday
// and minute of day, and compares against the trading window. Three register
// stages, the last one being the result register.
// ----------------------------------------------------------------------------
module eastw_local (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  eastw_pkg::civ_beat_t beat_i,
  input  eastw_pkg::win_cfg_t  cfg_i,
  output logic                 done_o,
  output logic                 window_open_o,
  output logic                 dst_active_o,
  output logic [2:0]           eastern_weekday_o,
  output logic [10:0]          eastern_minute_o
);
  import eastw_pkg::*;

  logic        v8_q, v9_q, done_q;
  logic [16:0] off;
  logic        same_day;
  logic [16:0] erem_d, erem_q;
  logic [2:0]  ewd_d, ewd8_q, ewd9_q;
  logic        dst8_q, dst9_q;
  logic [30:0] pm_d, pm_q;
  logic [10:0] minute;
  logic        open_d;
  logic        open_q, dst_q;
  logic [2:0]  wd_q;
  logic [10:0] min_q;

  // Offset the second of day; a borrow moves to the previous day.
  assign off      = beat_i.dst ? DST_OFFSET_S : STD_OFFSET_S;
  assign same_day = beat_i.sod >= off;
  always_comb begin
    if (same_day) begin
      erem_d = beat_i.sod - off;
      ewd_d  = beat_i.wday;
    end else begin
      erem_d = beat_i.sod + (SECS_PER_DAY - off);
      ewd_d  = (beat_i.wday == WD_SUNDAY) ? WD_SATURDAY : beat_i.wday - 3'd1;
    end
  end

  // Minute of day: (seconds >> 2) / 15 by reciprocal.
  assign pm_d   = 31'(erem_q[16:2]) * 31'(R15);
  assign minute = pm_q[29:19];

  // Window check on weekdays only.
  assign open_d = (ewd9_q >= WD_MONDAY) && (ewd9_q <= WD_FRIDAY)
               && (minute >= cfg_i.open_minute) && (minute < cfg_i.close_minute);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q   <= 1'b0;
      v9_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v8_q   <= beat_i.valid;
      v9_q   <= v8_q;
      done_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    erem_q <= erem_d;
    ewd8_q <= ewd_d;
    dst8_q <= beat_i.dst;
    pm_q   <= pm_d;
    ewd9_q <= ewd8_q;
    dst9_q <= dst8_q;
    open_q <= open_d;
    dst_q  <= dst9_q;
    wd_q   <= ewd9_q;
    min_q  <= minute;
  end

  assign done_o            = done_q;
  assign window_open_o     = open_q;
  assign dst_active_o      = dst_q;
  assign eastern_weekday_o = wd_q;
  assign eastern_minute_o  = min_q;

endmodule

### hdl/us_eastern_trading_window_check_unit.sv
// ----------------------------------------------------------------------------
// us_eastern_trading_window_check_unit
// Converts a Unix epoch to US Eastern weekday and minute with daylight saving
// and flags whether it falls inside the configured trading window.
//
// Usage:
//   Input: drive epoch_seconds_i and raise start_i. A beat is taken at every
//   rising edge with start_i high and busy_o low; busy_o is always low, so a
//   new epoch can be issued in every cycle.
//   Output: done_o is high for exactly one cycle per beat, with window_open_o,
//   dst_active_o, eastern_weekday_o and eastern_minute_o valid in that cycle.
//   Results leave in input order; the receiver must take them as they come.
//   Pipeline: done_o and the results leave through ten register stages:
//   two for the day split, five for the civil date and DST rule, three
//   for the Eastern shift, minute division and window compare.
//   Throughput: one beat per cycle.
//   Configuration: cfg_we_i writes cfg_wdata_i into the register chosen by
//   cfg_idx_i (0 open minute, 1 close minute); other indexes are ignored.
//   Write only while no beat is in flight.
//   Reset: the pipeline empties and the window returns to 09:30 to 16:00.
// ----------------------------------------------------------------------------
module us_eastern_trading_window_check_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] epoch_seconds_i,
  output logic        done_o,
  output logic        window_open_o,
  output logic        dst_active_o,
  output logic [2:0]  eastern_weekday_o,
  output logic [10:0] eastern_minute_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_wdata_i
);
  import eastw_pkg::*;

  logic        accept;
  logic [10:0] open_q, close_q;
  win_cfg_t    cfg;
  utc_beat_t   utc_beat;
  civ_beat_t   civ_beat;

  // The pipeline never stalls.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Window registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= OPEN_RESET;
      close_q <= CLOSE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OPEN_MINUTE:  open_q  <= cfg_wdata_i;
        REG_CLOSE_MINUTE: close_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.open_minute  = open_q;
    cfg.close_minute = close_q;
  end

  // UTC day and second of day.
  eastw_utc_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .epoch_i (epoch_seconds_i),
    .beat_o  (utc_beat)
  );

  // Civil date and daylight saving decision.
  eastw_civil u_civil (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (utc_beat),
    .beat_o (civ_beat)
  );

  // Eastern time and window check.
  eastw_local u_local (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .beat_i            (civ_beat),
    .cfg_i             (cfg),
    .done_o            (done_o),
    .window_open_o     (window_open_o),
    .dst_active_o      (dst_active_o),
    .eastern_weekday_o (eastern_weekday_o),
    .eastern_minute_o  (eastern_minute_o)
  );

endmodule

### sim/us_eastern_trading_window_check_unit_tb.sv
// ----------------------------------------------------------------------------
// us_eastern_trading_window_check_unit_tb
// Self-checking bench for the US Eastern trading-window check. Epochs go in
// through the start/busy command port, and each result beat is compared with
// an in-bench prediction of the UTC calendar, the US daylight-saving rule,
// the Eastern shift and the window compare. Directed epochs cover range ends,
// daylight-saving switch days and window edges. Register writes cover the
// extremes and the ignored indexes. Random phases then mix uniform epochs,
// epochs near switch days, near window edges and near the range ends, under
// several sender idle rates and window settings.
// ----------------------------------------------------------------------------
module us_eastern_trading_window_check_unit_tb;
  import eastw_pkg::*;

  localparam int         PIPE_LATENCY   = 10;
  localparam int         DRAIN_LIMIT    = 200;
  localparam int         PHASE_ITEMS    = 250;
  localparam longint     DAY_SECONDS    = 86400;
  localparam longint     EDT_OFFSET_S   = 4 * 3600;
  localparam longint     EST_OFFSET_S   = 5 * 3600;
  localparam longint     MONTH_MARCH    = 3;
  localparam longint     MONTH_NOVEMBER = 11;
  // Register indexes that the block has no register behind.
  localparam logic [1:0] REG_SPARE_A    = 2'd2;
  localparam logic [1:0] REG_SPARE_B    = 2'd3;

  typedef struct packed {
    logic        window_open;
    logic        dst_active;
    logic [2:0]  eastern_weekday;
    logic [10:0] eastern_minute;
  } window_result_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        start_i         = 1'b0;
  logic [31:0] epoch_seconds_i = '0;
  logic        cfg_we_i        = 1'b0;
  logic [1:0]  cfg_idx_i       = REG_OPEN_MINUTE;
  logic [10:0] cfg_wdata_i     = '0;
  logic        busy_o;
  logic        done_o;
  logic        window_open_o;
  logic        dst_active_o;
  logic [2:0]  eastern_weekday_o;
  logic [10:0] eastern_minute_o;

  // Mirror of the window registers and the results still owed by the block.
  win_cfg_t       window_cfg = '{open_minute: OPEN_RESET, close_minute: CLOSE_RESET};
  window_result_t pending_window_results[$];
  int             mismatch_count = 0;

  us_eastern_trading_window_check_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .epoch_seconds_i   (epoch_seconds_i),
    .done_o            (done_o),
    .window_open_o     (window_open_o),
    .dst_active_o      (dst_active_o),
    .eastern_weekday_o (eastern_weekday_o),
    .eastern_minute_o  (eastern_minute_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Eastern weekday, minute, daylight-saving flag and window flag of an epoch.
  function automatic window_result_t predict_window_check(input logic [31:0] epoch,
                                                          input win_cfg_t cfg);
    window_result_t r;
    longint utc_secs, utc_days, utc_wday, z, era_day, year_of_era, day_of_year;
    longint mp, month, mday, first_sunday, shifted, east_days, east_secs, east_wday;
    bit     dst;
    utc_secs = longint'(epoch);
    utc_days = utc_secs / DAY_SECONDS;
    utc_wday = (utc_days + 4) % 7;
    // Civil month and day, counting years from March 1.
    z           = utc_days + 719468;
    era_day     = z % 146097;
    year_of_era = (era_day - era_day / 1460 + era_day / 36524 - era_day / 146096) / 365;
    day_of_year = era_day - (365 * year_of_era + year_of_era / 4 - year_of_era / 100);
    mp          = (5 * day_of_year + 2) / 153;
    mday        = day_of_year - (153 * mp + 2) / 5 + 1;
    month       = (mp < 10) ? mp + 3 : mp - 9;
    // Daylight saving runs from the second Sunday of March up to the first
    // Sunday of November, judged on the UTC date.
    first_sunday = ((mday - utc_wday - 1) % 7 + 7) % 7 + 1;
    if (month < MONTH_MARCH || month > MONTH_NOVEMBER) begin
      dst = 1'b0;
    end else if (month > MONTH_MARCH && month < MONTH_NOVEMBER) begin
      dst = 1'b1;
    end else if (month == MONTH_MARCH) begin
      dst = (mday >= first_sunday + 7);
    end else begin
      dst = (mday < first_sunday);
    end
    // Shift to Eastern time with floor division, since it can fall before 1970.
    shifted   = utc_secs - (dst ? EDT_OFFSET_S : EST_OFFSET_S);
    east_days = shifted / DAY_SECONDS;
    east_secs = shifted % DAY_SECONDS;
    if (east_secs < 0) begin
      east_secs += DAY_SECONDS;
      east_days -= 1;
    end
    east_wday = ((east_days + 4) % 7 + 7) % 7;
    r.eastern_minute  = 11'(east_secs / 60);
    r.eastern_weekday = 3'(east_wday);
    r.dst_active      = dst;
    r.window_open     = (r.eastern_weekday >= WD_MONDAY) && (r.eastern_weekday <= WD_FRIDAY)
                        && (r.eastern_minute >= cfg.open_minute)
                        && (r.eastern_minute < cfg.close_minute);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [10:0] want,
                                      input logic [10:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Every done beat is matched against the oldest expectation.
  always @(posedge clk_i) begin
    window_result_t want;
    if (rst_ni && done_o) begin
      if (pending_window_results.size() == 0) begin
        $error("result beat with no epoch outstanding");
        mismatch_count++;
      end else begin
        want = pending_window_results.pop_front();
        check_field("window_open", 11'(want.window_open), 11'(window_open_o));
        check_field("dst_active", 11'(want.dst_active), 11'(dst_active_o));
        check_field("eastern_weekday", 11'(want.eastern_weekday),
                    11'(eastern_weekday_o));
        check_field("eastern_minute", want.eastern_minute, eastern_minute_o);
      end
    end
  end

  // Offer one epoch after a random gap and record its expected result.
  task automatic send_epoch(input logic [31:0] epoch, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i         <= 1'b1;
    epoch_seconds_i <= epoch;
    do begin
      @(posedge clk_i);
    end while (busy_o);
    pending_window_results.push_back(predict_window_check(epoch, window_cfg));
  endtask

  // Stop issuing and let every outstanding result come back.
  task automatic wait_drained();
    int waited;
    waited = 0;
    start_i <= 1'b0;
    while (pending_window_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_window_results.size() != 0) begin
      $error("%0d results never arrived", pending_window_results.size());
      mismatch_count += pending_window_results.size();
      pending_window_results.delete();
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // One register write; write enable is dropped again before the task returns.
  task automatic write_window_reg(input logic [1:0] idx, input logic [10:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_OPEN_MINUTE:  window_cfg.open_minute  = value;
      REG_CLOSE_MINUTE: window_cfg.close_minute = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Reset window: range ends, switch days, window edges, weekend and winter.
  task automatic test_reset_window();
    send_epoch(32'd0, 0);
    send_epoch(32'hFFFF_FFFF, 0);
    send_epoch(32'd1710028799, 0);  // last UTC second before the spring switch day
    send_epoch(32'd1710028800, 0);  // spring switch day, UTC midnight
    send_epoch(32'd1730591999, 0);  // last UTC second before the fall switch day
    send_epoch(32'd1730592000, 0);  // fall switch day, UTC midnight
    send_epoch(32'd1717421399, 0);  // Monday, one second before the open
    send_epoch(32'd1717421400, 0);  // Monday, at the open
    send_epoch(32'd1717444799, 0);  // Monday, last second before the close
    send_epoch(32'd1717444800, 0);  // Monday, at the close
    send_epoch(32'd1717858800, 0);  // Saturday, mid-morning
    send_epoch(32'd1717473570, 0);  // Monday, last Eastern minute of the day
    send_epoch(32'd1704205800, 0);  // winter Tuesday, at the open
    wait_drained();
  endtask

  // Register extremes, plus empty and inverted windows.
  task automatic test_register_extremes();
    write_window_reg(REG_OPEN_MINUTE, 11'd0);
    write_window_reg(REG_CLOSE_MINUTE, 11'd1440);
    send_epoch(32'd1717387200, 0);
    send_epoch(32'd1717473570, 0);
    wait_drained();
    write_window_reg(REG_OPEN_MINUTE, 11'd1439);
    write_window_reg(REG_CLOSE_MINUTE, 11'd2047);
    send_epoch(32'd1717473570, 0);
    wait_drained();
    write_window_reg(REG_OPEN_MINUTE, 11'd2047);
    send_epoch(32'd1717473570, 0);
    wait_drained();
    write_window_reg(REG_OPEN_MINUTE, 11'd1000);
    write_window_reg(REG_CLOSE_MINUTE, 11'd500);
    send_epoch(32'd1717421400, 0);
    wait_drained();
    write_window_reg(REG_OPEN_MINUTE, 11'd700);
    write_window_reg(REG_CLOSE_MINUTE, 11'd700);
    send_epoch(32'd1717444800, 0);
    wait_drained();
  endtask

  // Writes to indexes without a register must leave the window alone.
  task automatic test_unknown_index();
    write_window_reg(REG_OPEN_MINUTE, OPEN_RESET);
    write_window_reg(REG_CLOSE_MINUTE, CLOSE_RESET);
    write_window_reg(REG_SPARE_A, 11'd0);
    write_window_reg(REG_SPARE_B, 11'd2047);
    send_epoch(32'd1717421400, 0);
    send_epoch(32'd1717444800, 0);
    wait_drained();
  endtask

  // One random phase under a given window and sender idle rate.
  task automatic test_random_epochs(input int idle_pct, input logic [10:0] open_v,
                                    input logic [10:0] close_v);
    logic [31:0] epoch;
    longint      year, month, era, yoe, first_day, switch_day, edge_min, secs;
    int          roll;
    wait_drained();
    write_window_reg(REG_OPEN_MINUTE, open_v);
    write_window_reg(REG_CLOSE_MINUTE, close_v);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        epoch = $urandom();
      end else if (roll < 65) begin
        // Within two days of the spring or fall switch of a random year.
        year       = $urandom_range(1970, 2105);
        month      = $urandom_range(0, 1) ? MONTH_MARCH : MONTH_NOVEMBER;
        era        = year / 400;
        yoe        = year - era * 400;
        first_day  = era * 146097 + yoe * 365 + yoe / 4 - yoe / 100
                     + (153 * (month - 3) + 2) / 5 - 719468;
        switch_day = first_day + (7 - (first_day + 4) % 7) % 7
                     + ((month == MONTH_MARCH) ? 7 : 0);
        secs  = switch_day * DAY_SECONDS + longint'($urandom_range(0, 4 * 86400 - 1))
                - 2 * DAY_SECONDS;
        epoch = 32'(secs);
      end else if (roll < 90) begin
        // A couple of minutes around the open or the close on a random day.
        edge_min = $urandom_range(0, 1) ? longint'(window_cfg.open_minute)
                                        : longint'(window_cfg.close_minute);
        secs  = longint'($urandom_range(0, 49708)) * DAY_SECONDS + edge_min * 60
                + ($urandom_range(0, 1) ? EDT_OFFSET_S : EST_OFFSET_S)
                + longint'($urandom_range(0, 240)) - 120;
        epoch = 32'(secs);
      end else begin
        epoch = $urandom_range(0, 1) ? 32'($urandom_range(0, 20000))
                                     : 32'hFFFF_FFFF - 32'($urandom_range(0, 20000));
      end
      send_epoch(epoch, idle_pct);
    end
  endtask

  initial begin
    logic [10:0] open_r, close_r;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_window();
    test_register_extremes();
    test_unknown_index();
    test_random_epochs(0, OPEN_RESET, CLOSE_RESET);
    test_random_epochs(64, 11'd0, 11'd1440);
    open_r  = 11'($urandom_range(0, 1439));
    close_r = 11'($urandom_range(open_r, 1440));
    test_random_epochs(11, open_r, close_r);
    test_random_epochs(0, 11'd1439, 11'd2047);
    test_random_epochs(64, 11'($urandom()), 11'($urandom()));
    wait_drained();
    if (mismatch_count == 0) begin
      $display("us_eastern_trading_window_check_unit_tb: clean");
    end else begin
      $display("us_eastern_trading_window_check_unit_tb: errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake or a lost result.
  initial begin
    #400000;
    $display("us_eastern_trading_window_check_unit_tb: errors");
    $finish;
  end

endmodule
